@@ src/kft_pkg.sv @@
// Shared types, constants and command structs for the keyed file entry table.
`timescale 1ns / 1ps
`default_nettype none

package kft_pkg;

	// Table geometry.
	localparam int TABLE_DEPTH = 16;
	localparam int AW          = $clog2(TABLE_DEPTH);
	localparam int CW          = $clog2(TABLE_DEPTH + 1);

	// Field widths.
	localparam int NAME_W   = 64;
	localparam int TYPE_W   = 8;
	localparam int SIZE_W   = 8;
	localparam int ACCESS_W = 3;
	localparam int PTR_W    = 8;
	localparam int DATE_W   = 32;
	localparam int COUNT_W  = 5;
	localparam int REQ_W    = 2;
	localparam int STAT_W   = 2;

	// Port widths.
	localparam int IN_DATA_W  = 136;
	localparam int OUT_DATA_W = 64;
	localparam int CFG_W      = 8;

	// Values given to every new entry.
	localparam logic [ACCESS_W-1:0] NEW_ACCESS  = ACCESS_W'(7);
	localparam logic [PTR_W-1:0]    NEW_POINTER = '0;
	localparam logic [DATE_W-1:0]   NEW_DATE    = DATE_W'(1540000000);

	// Request codes.
	typedef enum logic [REQ_W-1:0] {
		REQ_ADD    = 2'd0,
		REQ_DELETE = 2'd1,
		REQ_FIND   = 2'd2,
		REQ_COUNT  = 2'd3
	} req_t;

	// Result status codes.
	typedef enum logic [STAT_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_MISSING = 2'd1,
		STAT_FULL    = 2'd2
	} stat_t;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD,
		S_SCAN,
		S_SH_RD,
		S_SH_WR,
		S_EMIT
	} state_t;

	// One table entry as held in the memory.
	typedef struct packed {
		logic [NAME_W-1:0] name_hi;
		logic [NAME_W-1:0] name_lo;
		logic [TYPE_W-1:0] etype;
		logic [SIZE_W-1:0] esize;
	} entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic          load_req;
		logic          rd_en;
		logic [AW-1:0] rd_addr;
		logic          wr_en;
		logic [AW-1:0] wr_addr;
		logic          wr_new;
		logic          cnt_inc;
		logic          cnt_dec;
		logic          track;
		logic          emit;
		stat_t         status;
		logic          show_rec;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [CW-1:0] count;
		logic          match;
		logic [AW-1:0] match_idx;
		logic          found_v;
		logic          out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

@@ src/kft_dp.sv @@
// Datapath: request latch, entry memory, key compare, entry count and output word register.
`timescale 1ns / 1ps
`default_nettype none

module kft_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire kft_pkg::dp_cmd_t              cmd,
	output kft_pkg::dp_stat_t                  stat,
	input  wire logic [kft_pkg::IN_DATA_W-1:0] s_tdata,
	input  wire logic                          cfg_valid,
	input  wire logic [kft_pkg::CFG_W-1:0]     cfg_data,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [kft_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic [kft_pkg::STAT_W-1:0]         m_tuser
);
	import kft_pkg::*;

	logic [NAME_W-1:0]  req_hi_q;
	logic [NAME_W-1:0]  req_lo_q;
	logic [TYPE_W-1:0]  req_type_q;
	logic [SIZE_W-1:0]  default_size_q;
	entry_t             mem_q [TABLE_DEPTH];
	entry_t             rd_data_s1;
	entry_t             wr_data;
	logic [AW-1:0]      rd_idx_s1;
	logic               rd_v_s1;
	logic               match_s1;
	logic [CW-1:0]      count_q;
	logic               found_v_q;
	logic [TYPE_W-1:0]  found_type_q;
	logic [SIZE_W-1:0]  found_size_q;
	logic               out_v_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	stat_t              out_stat_q;
	logic               out_free;

	// Request fields are captured when a word is accepted.
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_hi_q   <= s_tdata[63:0];
			req_lo_q   <= s_tdata[127:64];
			req_type_q <= s_tdata[135:128];
		end
	end

	// Size register for new entries; the port is always ready.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_size_q <= '0;
		end else if (cfg_valid) begin
			default_size_q <= cfg_data;
		end
	end

	// A write stores either the new entry or a word read for compaction.
	always_comb begin
		if (cmd.wr_new) begin
			wr_data = '{name_hi: req_hi_q, name_lo: req_lo_q,
				etype: req_type_q, esize: default_size_q};
		end else begin
			wr_data = rd_data_s1;
		end
	end

	// Entry memory: one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[cmd.wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_data_s1 <= mem_q[cmd.rd_addr];
			rd_idx_s1  <= cmd.rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= cmd.rd_en;
		end
	end

	// Full 16-byte key compare against the entry just read.
	assign match_s1 = rd_v_s1 && (rd_data_s1.name_hi == req_hi_q)
		&& (rd_data_s1.name_lo == req_lo_q);

	// Entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.cnt_inc) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.cnt_dec) begin
			count_q <= count_q - CW'(1);
		end
	end

	// The last matching entry of a find scan wins.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_v_q <= 1'b0;
		end else if (cmd.load_req) begin
			found_v_q <= 1'b0;
		end else if (cmd.track && match_s1) begin
			found_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.track && match_s1) begin
			found_type_q <= rd_data_s1.etype;
			found_size_q <= rd_data_s1.esize;
		end
	end

	// Output word register; a new word may load as the old one leaves.
	assign out_free = !out_v_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (cmd.emit) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_stat_q <= cmd.status;
			if (cmd.show_rec) begin
				out_data_q <= {COUNT_W'(count_q), NEW_DATE, NEW_POINTER,
					found_size_q, NEW_ACCESS, found_type_q};
			end else begin
				out_data_q <= {COUNT_W'(count_q), (OUT_DATA_W - COUNT_W)'(0)};
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_stat_q;

	assign stat.count     = count_q;
	assign stat.match     = match_s1;
	assign stat.match_idx = rd_idx_s1;
	assign stat.found_v   = found_v_q;
	assign stat.out_free  = out_free;

	// The count never passes the table depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count above table depth");

	// An append happens only with room left.
	a_inc_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_inc |-> count_q < CW'(TABLE_DEPTH))
		else $error("append into a full table");

	// A removal happens only from a non-empty table.
	a_dec_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_dec |-> count_q != '0)
		else $error("removal from an empty table");

	// A result is loaded only when the output register can take it.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> out_free)
		else $error("result word overwritten");

endmodule

`default_nettype wire

@@ src/kft_ctrl.sv @@
// Controller: sequences add, scan, compaction and result emission.
`timescale 1ns / 1ps
`default_nettype none

module kft_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	input  wire logic [kft_pkg::REQ_W-1:0] s_tuser,
	input  wire kft_pkg::dp_stat_t         stat,
	output kft_pkg::dp_cmd_t               cmd
);
	import kft_pkg::*;

	state_t        state_q, state_d;
	req_t          op_q, op_d;
	logic [CW-1:0] ptr_q, ptr_d;
	logic [CW-1:0] ptr_nx;
	stat_t         st_q, st_d;

	assign ptr_nx = ptr_q + CW'(1);

	// State and working registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= REQ_COUNT;
			ptr_q   <= '0;
			st_q    <= STAT_OK;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			ptr_q   <= ptr_d;
			st_q    <= st_d;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d  = state_q;
		op_d     = op_q;
		ptr_d    = ptr_q;
		st_d     = st_q;
		s_tready = 1'b0;
		cmd      = '0;
		cmd.status = st_q;
		cmd.track  = (op_q == REQ_FIND) && (state_q == S_SCAN);

		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_req = 1'b1;
					op_d  = req_t'(s_tuser);
					ptr_d = '0;
					st_d  = STAT_OK;
					unique case (req_t'(s_tuser))
						REQ_ADD:    state_d = S_ADD;
						REQ_DELETE: state_d = S_SCAN;
						REQ_FIND:   state_d = S_SCAN;
						REQ_COUNT:  state_d = S_EMIT;
						default:    state_d = S_EMIT;
					endcase
				end
			end

			S_ADD: begin
				if (stat.count >= CW'(TABLE_DEPTH)) begin
					st_d = STAT_FULL;
				end else begin
					cmd.wr_en   = 1'b1;
					cmd.wr_addr = stat.count[AW-1:0];
					cmd.wr_new  = 1'b1;
					cmd.cnt_inc = 1'b1;
					st_d        = STAT_OK;
				end
				state_d = S_EMIT;
			end

			// One read per cycle; the compare uses the registered read data in the cycle after the read.
			S_SCAN: begin
				if ((op_q == REQ_DELETE) && stat.match) begin
					ptr_d   = CW'(stat.match_idx);
					state_d = S_SH_RD;
				end else if (ptr_q < stat.count) begin
					cmd.rd_en   = 1'b1;
					cmd.rd_addr = ptr_q[AW-1:0];
					ptr_d       = ptr_nx;
				end else begin
					if ((op_q == REQ_FIND) && (stat.found_v || stat.match)) begin
						st_d = STAT_OK;
					end else begin
						st_d = STAT_MISSING;
					end
					state_d = S_EMIT;
				end
			end

			// Compaction: read the next entry, then write it one slot down.
			S_SH_RD: begin
				if (ptr_nx < stat.count) begin
					cmd.rd_en   = 1'b1;
					cmd.rd_addr = ptr_nx[AW-1:0];
					state_d     = S_SH_WR;
				end else begin
					cmd.cnt_dec = 1'b1;
					st_d        = STAT_OK;
					state_d     = S_EMIT;
				end
			end

			S_SH_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_addr = ptr_q[AW-1:0];
				ptr_d       = ptr_nx;
				state_d     = S_SH_RD;
			end

			S_EMIT: begin
				if (stat.out_free) begin
					cmd.emit     = 1'b1;
					cmd.show_rec = (op_q == REQ_FIND) && (st_q == STAT_OK);
					state_d      = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// The scan pointer stays within the entry count.
	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> ptr_q <= stat.count)
		else $error("scan pointer past entry count");

	// A full status is emitted only when the table holds its full depth of entries.
	a_full_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && st_q == STAT_FULL) |-> stat.count == CW'(TABLE_DEPTH))
		else $error("full status with room in the table");

	// Writes happen only while adding or compacting.
	a_wr_state: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> (state_q == S_ADD || state_q == S_SH_WR))
		else $error("memory write outside add or compaction");

endmodule

`default_nettype wire

@@ src/keyed_file_entry_table.sv @@
// Top level of the keyed file entry table: controller plus datapath.
//
// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid/s_tready    tuser: req_type; tdata: name_hi, name_lo, entry_type
// m_*       out  m_tvalid/m_tready    tuser: status; tdata: record fields, entry_count
// cfg_*     in   cfg_valid/cfg_ready  default_size
//
// Count query: acceptance in S_IDLE, then S_EMIT loads the result word; add: S_ADD, then S_EMIT.
// Find: S_SCAN reads every entry, one entry compared per cycle on the single memory read port, then S_EMIT.
// Delete: scan up to the first match, then S_SH_RD and S_SH_WR for each entry moved down the table.
// Reset leaves the table empty and the size register at zero; no clearing pass.
// A result waiting in the output register holds only the next result, not the next request.
`timescale 1ns / 1ps
`default_nettype none

module keyed_file_entry_table (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// tdata: name_hi [63:0], name_lo [127:64], entry_type [135:128]
	input  wire logic [kft_pkg::IN_DATA_W-1:0]  s_tdata,
	// tuser: req_type [1:0]
	input  wire logic [kft_pkg::REQ_W-1:0]      s_tuser,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// tdata: rec_type [7:0], rec_access [10:8], rec_size [18:11],
	// rec_pointer [26:19], rec_date [58:27], entry_count [63:59]
	output logic [kft_pkg::OUT_DATA_W-1:0]      m_tdata,
	// tuser: status [1:0]
	output logic [kft_pkg::STAT_W-1:0]          m_tuser,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [kft_pkg::CFG_W-1:0]      cfg_data
);
	import kft_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// The size register takes a write in any cycle.
	assign cfg_ready = 1'b1;

	// Request sequencing.
	kft_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Storage, compare and result register.
	kft_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

`default_nettype wire

@@ tb/sv/tb_keyed_file_entry_table.sv @@
// Self-checking testbench for the keyed file entry table: directed and random requests.
`timescale 1ns / 1ps

module tb_keyed_file_entry_table;
	import kft_pkg::*;

	localparam int CLK_HALF = 10;
	localparam int RESET_CYCLES = 12;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int POOL_MAX = 24;
	localparam int LONG_HOLD = 500;
	localparam int HOLD_AFTER_WORDS = 300;
	localparam int REPORT_LIMIT = 10;

	// Fixed fields of a freshly added entry.
	localparam logic [2:0]  ADDED_ACCESS  = 3'd7;
	localparam logic [7:0]  ADDED_POINTER = 8'd0;
	localparam logic [31:0] ADDED_DATE    = 32'd1540000000;

	// Names for the directed part: two that differ only past a zero byte.
	localparam logic [63:0] TWIN_HI     = 64'h0000_0000_0000_6162;
	localparam logic [63:0] TWIN_ALT_HI = 64'h7A00_0000_0000_6162;

	typedef struct packed {
		req_t        kind;
		logic [63:0] hi;
		logic [63:0] lo;
		logic [7:0]  etype;
	} request_t;

	typedef struct packed {
		stat_t       status;
		logic [7:0]  rtype;
		logic [2:0]  access;
		logic [7:0]  size;
		logic [7:0]  pointer;
		logic [31:0] date;
		logic [4:0]  count;
	} table_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic [REQ_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [STAT_W-1:0] m_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_W-1:0] cfg_data = '0;

	// Shadow copy of the table contents and the size register.
	logic [63:0] tbl_hi [0:TABLE_DEPTH-1];
	logic [63:0] tbl_lo [0:TABLE_DEPTH-1];
	logic [7:0]  tbl_type [0:TABLE_DEPTH-1];
	logic [7:0]  tbl_size [0:TABLE_DEPTH-1];
	int          entry_total = 0;
	logic [7:0]  size_reg = 8'd0;

	request_t      requests_waiting [$];
	table_result_t results_due [$];
	request_t      offered;
	int            requests_queued = 0;
	int            sent_total = 0;
	int            gap_left = 0;
	int            stall_left = 0;
	int            hold_left = 0;
	logic          held_once = 1'b0;
	int            words_taken = 0;
	bit            calm = 1'b0;
	int            fail_count = 0;
	int            cycle_count = 0;

	logic [63:0] pool_hi [0:POOL_MAX-1];
	logic [63:0] pool_lo [0:POOL_MAX-1];

	keyed_file_entry_table DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #(CLK_HALF) clk = ~clk;

	// Apply one request to the shadow table and return the word it should produce.
	function automatic table_result_t apply_request(input request_t r);
		table_result_t res;
		int hit;
		int i;
		res = '0;
		res.status = STAT_OK;
		hit = -1;
		case (r.kind)
			REQ_ADD: begin
				if (entry_total >= TABLE_DEPTH) begin
					res.status = STAT_FULL;
				end else begin
					tbl_hi[entry_total] = r.hi;
					tbl_lo[entry_total] = r.lo;
					tbl_type[entry_total] = r.etype;
					tbl_size[entry_total] = size_reg;
					entry_total++;
				end
			end
			REQ_DELETE: begin
				// The first matching entry goes; later ones move down one place.
				for (i = 0; i < entry_total; i++)
					if (hit < 0 && tbl_hi[i] == r.hi && tbl_lo[i] == r.lo)
						hit = i;
				if (hit < 0) begin
					res.status = STAT_MISSING;
				end else begin
					for (i = hit; i + 1 < entry_total; i++) begin
						tbl_hi[i] = tbl_hi[i+1];
						tbl_lo[i] = tbl_lo[i+1];
						tbl_type[i] = tbl_type[i+1];
						tbl_size[i] = tbl_size[i+1];
					end
					entry_total--;
				end
			end
			REQ_FIND: begin
				// The last matching entry answers.
				for (i = 0; i < entry_total; i++)
					if (tbl_hi[i] == r.hi && tbl_lo[i] == r.lo)
						hit = i;
				if (hit < 0) begin
					res.status = STAT_MISSING;
				end else begin
					res.rtype = tbl_type[hit];
					res.access = ADDED_ACCESS;
					res.size = tbl_size[hit];
					res.pointer = ADDED_POINTER;
					res.date = ADDED_DATE;
				end
			end
			default: ;
		endcase
		res.count = 5'(entry_total);
		return res;
	endfunction

	function automatic string describe(input table_result_t r);
		return $sformatf("status %0d type %02h access %0d size %02h ptr %02h date %0d count %0d",
			r.status, r.rtype, r.access, r.size, r.pointer, r.date, r.count);
	endfunction

	task automatic flag_failure(input string what);
		fail_count++;
		if (fail_count <= REPORT_LIMIT)
			$display("%s", what);
	endtask

	task automatic queue_req(input req_t kind, input logic [63:0] hi, input logic [63:0] lo,
			input logic [7:0] etype);
		request_t r;
		r.kind = kind;
		r.hi = hi;
		r.lo = lo;
		r.etype = etype;
		requests_waiting.push_back(r);
		requests_queued++;
	endtask

	// Returns once every request is taken and answered.
	task automatic wait_idle();
		while (sent_total != requests_queued || results_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_default_size(input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		size_reg = value;
		cfg_valid <= 1'b0;
	endtask

	// One phase: new size setting, fresh name pool, a burst of random requests.
	task automatic run_phase(input logic [7:0] size_value, input int n_items, input int add_pct,
			input int pool_n);
		int i;
		int roll;
		int rest;
		req_t kind;
		logic [63:0] hi;
		logic [63:0] lo;
		write_default_size(size_value);
		for (i = 0; i < POOL_MAX; i++) begin
			pool_hi[i] = {$urandom, $urandom};
			pool_lo[i] = {$urandom, $urandom};
			if (i % 3 == 1) begin
				// Twin that differs from its neighbor only past a zero byte.
				pool_hi[i-1][23:16] = 8'h00;
				pool_hi[i] = pool_hi[i-1] ^ 64'h0000_0100_0000_0000;
				pool_lo[i] = pool_lo[i-1];
			end else if (i % 3 == 2) begin
				// Twin that differs only in one bit of the low half.
				pool_hi[i] = pool_hi[i-2];
				pool_lo[i] = pool_lo[i-2] ^ (64'd1 << $urandom_range(0, 63));
			end
		end
		rest = 100 - add_pct;
		for (i = 0; i < n_items; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < add_pct)
				kind = REQ_ADD;
			else if (roll < add_pct + rest * 2 / 5)
				kind = REQ_DELETE;
			else if (roll < add_pct + rest * 17 / 20)
				kind = REQ_FIND;
			else
				kind = REQ_COUNT;
			if ($urandom_range(0, 99) < 85) begin
				roll = $urandom_range(0, pool_n - 1);
				hi = pool_hi[roll];
				lo = pool_lo[roll];
			end else begin
				hi = {$urandom, $urandom};
				lo = {$urandom, $urandom};
			end
			queue_req(kind, hi, lo, 8'($urandom_range(0, 255)));
		end
		wait_idle();
	endtask

	// Request driver: offers queued requests with random gaps.
	always @(posedge clk) begin : drive_requests
		request_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				results_due.push_back(apply_request(offered));
				sent_total++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					s_tvalid <= 1'b0;
				end else if (!calm && $urandom_range(0, 7) == 0) begin
					gap_left <= $urandom_range(0, 15);
					s_tvalid <= 1'b0;
				end else if (requests_waiting.size() != 0) begin
					nxt = requests_waiting.pop_front();
					offered <= nxt;
					s_tvalid <= 1'b1;
					s_tdata <= {nxt.etype, nxt.lo, nxt.hi};
					s_tuser <= nxt.kind;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result receiver: random stalls plus one long hold that backs the table up.
	always @(posedge clk) begin : accept_results
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				words_taken++;
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
			end else if (!held_once && words_taken >= HOLD_AFTER_WORDS) begin
				held_once <= 1'b1;
				hold_left <= LONG_HOLD - 1;
				m_tready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left <= $urandom_range(0, 15);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Result monitor: every word taken is checked against the oldest expectation.
	always @(posedge clk) begin : check_results
		table_result_t got;
		table_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.status = stat_t'(m_tuser);
			got.rtype = m_tdata[7:0];
			got.access = m_tdata[10:8];
			got.size = m_tdata[18:11];
			got.pointer = m_tdata[26:19];
			got.date = m_tdata[58:27];
			got.count = m_tdata[63:59];
			if (results_due.size() == 0) begin
				flag_failure($sformatf("unexpected result word: %s", describe(got)));
			end else begin
				want = results_due.pop_front();
				if (got !== want)
					flag_failure($sformatf("result word mismatch:\n  expected %s\n  got      %s",
						describe(want), describe(got)));
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin : watchdog
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still expected", cycle_count,
				results_due.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	// Stimulus sequence.
	initial begin : stimulus
		int i;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, with the size register still at its reset value.
		queue_req(REQ_COUNT, 64'd0, 64'd0, 8'hFF);
		queue_req(REQ_FIND, 64'd0, 64'd0, 8'h00);
		queue_req(REQ_DELETE, 64'd0, 64'd0, 8'h00);
		queue_req(REQ_ADD, 64'd0, 64'd0, 8'h00);
		queue_req(REQ_ADD, '1, '1, 8'hFF);
		queue_req(REQ_ADD, TWIN_HI, 64'd0, 8'h11);
		queue_req(REQ_ADD, TWIN_ALT_HI, 64'd0, 8'h22);
		queue_req(REQ_ADD, 64'd0, 64'd0, 8'h5A);
		queue_req(REQ_FIND, TWIN_HI, 64'd0, 8'h00);
		queue_req(REQ_FIND, 64'd0, 64'd0, 8'hFF);
		queue_req(REQ_FIND, TWIN_HI, 64'd1, 8'h00);
		queue_req(REQ_DELETE, 64'd0, 64'd0, 8'h00);
		queue_req(REQ_FIND, 64'd0, 64'd0, 8'h00);
		// Fill the table, then one add too many.
		for (i = 0; i < 12; i++)
			queue_req(REQ_ADD, {$urandom, $urandom}, {$urandom, $urandom},
				8'($urandom_range(0, 255)));
		queue_req(REQ_ADD, 64'd5, 64'd5, 8'h33);
		queue_req(REQ_DELETE, TWIN_HI, 64'd0, 8'h00);
		queue_req(REQ_FIND, TWIN_ALT_HI, 64'd0, 8'h00);
		wait_idle();

		// Random phases over a range of size settings and request mixes.
		run_phase(8'hFF, 200, 55, 8);
		run_phase(8'h00, 200, 45, 12);
		run_phase(8'($urandom_range(0, 255)), 200, 35, 6);
		run_phase(8'h80, 200, 60, 20);
		run_phase(8'h01, 200, 40, 4);
		run_phase(8'($urandom_range(0, 255)), 200, 50, 16);
		calm = 1'b1;
		run_phase(8'h7F, 200, 50, 10);
		run_phase(8'($urandom_range(0, 255)), 200, 45, 8);

		wait_idle();
		repeat (60) @(posedge clk);
		if (fail_count == 0 && results_due.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

@@ filelist.f @@
src/kft_pkg.sv
src/kft_dp.sv
src/kft_ctrl.sv
src/keyed_file_entry_table.sv
tb/sv/tb_keyed_file_entry_table.sv
